>>> design/rcs_pkg.sv
package rcs_pkg;

   localparam int PIXEL_W        = 8;
   localparam int IMAGE_WIDTH_W  = 12;
   localparam int IMAGE_HEIGHT_W = 16;
   localparam int CSR_DATA_W     = 16;
   localparam int CSR_INDEX_W    = 1;
   localparam int MAX_RESULTS    = 3;
   localparam int RESULT_COUNT_W = 2;

   localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 12'd640;
   localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 16'd480;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'd255;
   localparam int                 KERNEL_GAIN = 5;

   typedef struct packed {
      logic [PIXEL_W-1:0] red;
      logic [PIXEL_W-1:0] green;
      logic [PIXEL_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_red;
      logic [PIXEL_W-1:0] pixel_green;
      logic [PIXEL_W-1:0] pixel_blue;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] sharp_red;
      logic [PIXEL_W-1:0] sharp_green;
      logic [PIXEL_W-1:0] sharp_blue;
      logic               run_last;
      logic               frame_end;
   } rsp_payload_type;

   typedef struct packed {
      logic row_ge1;
      logic first_col;
      logic col_ge2;
      logic last_col;
      logic last_row;
   } stage_flags_type;

endpackage

>>> design/rcs_kernel.sv
module rcs_kernel import rcs_pkg::*; (
   input  pixel_type centre,
   input  pixel_type up,
   input  pixel_type down,
   input  pixel_type left,
   input  pixel_type right,
   output pixel_type result
);

   function automatic logic [PIXEL_W-1:0] sharpen_chan(
      input logic [PIXEL_W-1:0] c,
      input logic [PIXEL_W-1:0] u,
      input logic [PIXEL_W-1:0] d,
      input logic [PIXEL_W-1:0] l,
      input logic [PIXEL_W-1:0] r
   );
      logic [11:0] pos;
      logic [11:0] neg;
      logic [11:0] diff;
      logic [PIXEL_W-1:0] clamped;
      pos  = 12'(KERNEL_GAIN) * {4'b0, c};
      neg  = {4'b0, u} + {4'b0, d} + {4'b0, l} + {4'b0, r};
      diff = pos - neg;
      if (diff[11]) begin
         clamped = '0;
      end else if (diff > {4'b0, PIXEL_MAX}) begin
         clamped = PIXEL_MAX;
      end else begin
         clamped = diff[PIXEL_W-1:0];
      end
      return clamped;
   endfunction

   assign result.red   = sharpen_chan(centre.red, up.red, down.red, left.red, right.red);
   assign result.green = sharpen_chan(centre.green, up.green, down.green, left.green,
                                      right.green);
   assign result.blue  = sharpen_chan(centre.blue, up.blue, down.blue, left.blue, right.blue);

endmodule

>>> design/rcs_line_buffer.sv
module rcs_line_buffer import rcs_pkg::*; #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   input  logic [AW-1:0] rd_next_addr,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  pixel_type     wr_centre,
   input  pixel_type     wr_above,
   output pixel_type     centre_q,
   output pixel_type     right_q,
   output pixel_type     above_q
);

   pixel_type centre_mem [DEPTH];
   pixel_type above_mem  [DEPTH];
   pixel_type centre_ff;
   pixel_type right_ff;
   pixel_type above_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         centre_mem[wr_addr] <= wr_centre;
         above_mem[wr_addr]  <= wr_above;
      end
      if (rd_en) begin
         centre_ff <= (wr_en && wr_addr == rd_addr) ? wr_centre : centre_mem[rd_addr];
         right_ff  <= (wr_en && wr_addr == rd_next_addr) ? wr_centre
                                                         : centre_mem[rd_next_addr];
         above_ff  <= (wr_en && wr_addr == rd_addr) ? wr_above : above_mem[rd_addr];
      end
   end

   assign centre_q = centre_ff;
   assign right_q  = right_ff;
   assign above_q  = above_ff;

endmodule

>>> design/rcs_result_queue.sv
module rcs_result_queue import rcs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  logic [RESULT_COUNT_W-1:0] load_count,
   input  rsp_payload_type           load_items [MAX_RESULTS],
   output logic                      load_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_payload_type           rsp_payload
);

   logic [RESULT_COUNT_W-1:0] count_ff;
   rsp_payload_type           slot_ff [MAX_RESULTS];
   logic                      pop;

   assign pop        = (count_ff != '0) && !rsp_stall;
   assign load_ready = (count_ff == '0) || (count_ff == RESULT_COUNT_W'(1) && !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (load) begin
         count_ff <= load_count;
      end else if (pop) begin
         count_ff <= count_ff - RESULT_COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= load_items;
      end else if (pop) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            slot_ff[i] <= slot_ff[i+1];
         end
      end
   end

   assign rsp_valid   = count_ff != '0;
   assign rsp_payload = slot_ff[0];

endmodule

>>> design/rgb_cross_sharpen_filter_top.sv
// RGB cross-kernel sharpen filter.
// Pixels enter in raster order on req_ (valid/stall); an item is taken at a clock edge with
// req_valid high and req_stall low. Each output pixel is 5*centre minus its four neighbors,
// per channel, clamped to 0..255, with edge pixels replicated past the border.
// Results leave on rsp_ in raster order. Output pixel (r-1,c) is produced by input (r,c);
// on the last row, input (r,c) also produces (r,c-1), and the final input adds (r,c) with
// frame_end set. run_last marks the last result of each input item.
// Geometry is written on csr_: index CSR_IMAGE_WIDTH (12 bits), CSR_IMAGE_HEIGHT (16 bits).
// The user must write it only while no item is in flight; the block does not enforce this.
// Throughput: one item per cycle outside the last row while rsp_stall is low; on the last
// row an item has up to two results and the final item three, which leave one at a time by
// the single result port; the next item is taken as the last one leaves. Two MAX_WIDTH-pixel
// line stores hold the rows; each takes one write a cycle, the centre store two reads, the
// above one. Reset clears counters, pipeline and result queue and loads 640 x 480; the line
// stores are not cleared and need no clearing pass. When rsp_stall is high, pending results
// hold; req_stall rises when the input stage is full and the queue cannot take its results.
module rgb_cross_sharpen_filter_top import rcs_pkg::*; #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = (AW + 1 > IMAGE_WIDTH_W) ? AW + 1 : IMAGE_WIDTH_W;
   localparam int HW = IMAGE_HEIGHT_W + 1;

   logic [IMAGE_WIDTH_W-1:0]  image_width_ff;
   logic [IMAGE_HEIGHT_W-1:0] image_height_ff;
   logic [AW-1:0]             col_ff;
   logic [IMAGE_HEIGHT_W-1:0] row_ff;

   logic                      s1_valid_ff;
   pixel_type                 s1_pixel_ff;
   logic [AW-1:0]             s1_addr_ff;
   stage_flags_type           s1_flags_ff;

   pixel_type                 win0_ff;
   pixel_type                 win1_ff;
   pixel_type                 win2_ff;
   pixel_type                 prev_above_ff;

   logic                      req_accept;
   logic                      s1_advance;
   logic                      load_ready;

   logic [WW-1:0]             width_eff;
   logic [WW-1:0]             col_plus1;
   logic [HW-1:0]             height_eff;
   logic [HW-1:0]             row_plus1;
   logic [AW-1:0]             next_addr;
   stage_flags_type           flags_in;
   logic [AW-1:0]             col_in;
   logic [IMAGE_HEIGHT_W-1:0] row_in;

   pixel_type                 in_pixel;
   pixel_type                 centre_q;
   pixel_type                 right_q;
   pixel_type                 above_q;
   pixel_type                 left_a;
   pixel_type                 right_a;
   pixel_type                 above_wr;
   pixel_type                 left_b;
   pixel_type                 left_c;
   pixel_type                 res_a;
   pixel_type                 res_b;
   pixel_type                 res_c;
   logic                      has_a;
   logic                      has_b;
   logic                      has_c;
   rsp_payload_type           item_a;
   rsp_payload_type           item_b;
   rsp_payload_type           item_c;
   rsp_payload_type           load_items [MAX_RESULTS];
   logic [RESULT_COUNT_W-1:0] load_count;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_write_data[IMAGE_WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_write_data[IMAGE_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // geometry and position of the incoming item
   always_comb begin
      if (image_width_ff == '0) begin
         width_eff = WW'(1);
      end else if (WW'(image_width_ff) > WW'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(image_width_ff);
      end
      height_eff = (image_height_ff == '0) ? HW'(1) : HW'(image_height_ff);
      col_plus1  = WW'(col_ff) + WW'(1);
      row_plus1  = HW'(row_ff) + HW'(1);
      next_addr  = (col_plus1 >= WW'(MAX_WIDTH)) ? AW'(MAX_WIDTH - 1) : col_plus1[AW-1:0];

      flags_in.row_ge1   = row_ff != '0;
      flags_in.first_col = col_ff == '0;
      flags_in.col_ge2   = WW'(col_ff) >= WW'(2);
      flags_in.last_col  = col_plus1 >= width_eff;
      flags_in.last_row  = row_plus1 >= height_eff;

      if (flags_in.last_col) begin
         col_in = '0;
         row_in = flags_in.last_row ? '0 : row_plus1[IMAGE_HEIGHT_W-1:0];
      end else begin
         col_in = col_plus1[AW-1:0];
         row_in = row_ff;
      end
   end

   assign req_accept = req_valid && !req_stall;
   assign s1_advance = s1_valid_ff && load_ready;
   assign req_stall  = s1_valid_ff && !load_ready;

   assign in_pixel.red   = req_payload.pixel_red;
   assign in_pixel.green = req_payload.pixel_green;
   assign in_pixel.blue  = req_payload.pixel_blue;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= in_pixel;
         s1_addr_ff  <= col_ff;
         s1_flags_ff <= flags_in;
      end
   end

   rcs_line_buffer #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_line_buffer (
      .clock        (clock),
      .rd_en        (req_accept),
      .rd_addr      (col_ff),
      .rd_next_addr (next_addr),
      .wr_en        (s1_advance),
      .wr_addr      (s1_addr_ff),
      .wr_centre    (s1_pixel_ff),
      .wr_above     (above_wr),
      .centre_q     (centre_q),
      .right_q      (right_q),
      .above_q      (above_q)
   );

   // neighbors of the three possible output pixels
   assign left_a   = s1_flags_ff.first_col ? centre_q : win0_ff;
   assign right_a  = s1_flags_ff.last_col ? centre_q : right_q;
   assign above_wr = s1_flags_ff.row_ge1 ? centre_q : s1_pixel_ff;
   assign left_b   = s1_flags_ff.col_ge2 ? win2_ff : win1_ff;
   assign left_c   = s1_flags_ff.first_col ? s1_pixel_ff : win1_ff;

   rcs_kernel u_kernel_a (
      .centre (centre_q),
      .up     (above_q),
      .down   (s1_pixel_ff),
      .left   (left_a),
      .right  (right_a),
      .result (res_a)
   );

   rcs_kernel u_kernel_b (
      .centre (win1_ff),
      .up     (prev_above_ff),
      .down   (win1_ff),
      .left   (left_b),
      .right  (s1_pixel_ff),
      .result (res_b)
   );

   rcs_kernel u_kernel_c (
      .centre (s1_pixel_ff),
      .up     (above_wr),
      .down   (s1_pixel_ff),
      .left   (left_c),
      .right  (s1_pixel_ff),
      .result (res_c)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         win0_ff <= '0;
         win1_ff <= '0;
         win2_ff <= '0;
      end else if (s1_advance) begin
         if (s1_flags_ff.row_ge1) begin
            win0_ff <= centre_q;
         end
         win1_ff <= s1_pixel_ff;
         win2_ff <= win1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         prev_above_ff <= above_wr;
      end
   end

   // pack results in order
   always_comb begin
      has_a = s1_flags_ff.row_ge1;
      has_b = s1_flags_ff.last_row && !s1_flags_ff.first_col;
      has_c = s1_flags_ff.last_row && s1_flags_ff.last_col;

      item_a.sharp_red   = res_a.red;
      item_a.sharp_green = res_a.green;
      item_a.sharp_blue  = res_a.blue;
      item_a.run_last    = !has_b && !has_c;
      item_a.frame_end   = 1'b0;

      item_b.sharp_red   = res_b.red;
      item_b.sharp_green = res_b.green;
      item_b.sharp_blue  = res_b.blue;
      item_b.run_last    = !has_c;
      item_b.frame_end   = 1'b0;

      item_c.sharp_red   = res_c.red;
      item_c.sharp_green = res_c.green;
      item_c.sharp_blue  = res_c.blue;
      item_c.run_last    = 1'b1;
      item_c.frame_end   = 1'b1;

      load_items[0] = has_a ? item_a : (has_b ? item_b : item_c);
      load_items[1] = (has_a && has_b) ? item_b : item_c;
      load_items[2] = item_c;
      load_count    = RESULT_COUNT_W'(has_a) + RESULT_COUNT_W'(has_b)
                    + RESULT_COUNT_W'(has_c);
   end

   rcs_result_queue u_result_queue (
      .clock       (clock),
      .reset       (reset),
      .load        (s1_advance),
      .load_count  (load_count),
      .load_items  (load_items),
      .load_ready  (load_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> design/rcs_checker.sv
module rcs_checker import rcs_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or dropped");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_end |-> rsp_payload.run_last)
      else $error("frame end not on last result of its item");

   // input backs up only behind a pending result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no pending result");

endmodule

bind rgb_cross_sharpen_filter_top rcs_checker u_rcs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
